// ===== sv/im_text_block_to_html_text_assert.svh =====
// Assertion macros shared by the text extractor modules
`ifndef IM_TEXT_BLOCK_TO_HTML_TEXT_ASSERT_SVH
`define IM_TEXT_BLOCK_TO_HTML_TEXT_ASSERT_SVH

// clocked check, off while reset is asserted
`define IMTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define IMTB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/imtb_pkg.sv =====
// Types, codes and helpers for the message-block text extractor
package imtb_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_valid;
		logic       run_end;
		logic       message_done;
		logic [1:0] status;
	} out_item_t;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_ENT  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNREP = 2'd1;
	localparam logic [1:0] ST_ERR   = 2'd2;

	localparam logic [1:0] KIND_COPY = 2'd0;
	localparam logic [1:0] KIND_WIDE = 2'd1;
	localparam logic [1:0] KIND_SKIP = 2'd2;

	localparam logic [7:0]  HDR_B0      = 8'h05;
	localparam logic [7:0]  MARK_B      = 8'h01;
	localparam logic [15:0] FLAG_PLAIN  = 16'h0000;
	localparam logic [15:0] FLAG_PLAIN3 = 16'h0003;
	localparam logic [15:0] FLAG_WIDE   = 16'h0002;
	localparam logic [15:0] ASCII_LIMIT = 16'd128;
	localparam logic [15:0] SECT_MIN    = 16'd4;

	localparam logic [2:0] ENT_LAST = 3'd6;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] word;
		logic        done;
		logic [1:0]  status;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h57 + {4'h0, nib};
		end
		return r;
	endfunction

endpackage

// ===== sv/imtb_front.sv =====
// Front end: header and section parser that turns input bytes into commands
`include "im_text_block_to_html_text_assert.svh"

module imtb_front import imtb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     cmd_push,
	output cmd_t     cmd
);

	localparam logic [3:0] PH_H0     = 4'd0;
	localparam logic [3:0] PH_H1     = 4'd1;
	localparam logic [3:0] PH_FL_HI  = 4'd2;
	localparam logic [3:0] PH_FL_LO  = 4'd3;
	localparam logic [3:0] PH_FEAT   = 4'd4;
	localparam logic [3:0] PH_S0     = 4'd5;
	localparam logic [3:0] PH_S1     = 4'd6;
	localparam logic [3:0] PH_LEN_HI = 4'd7;
	localparam logic [3:0] PH_LEN_LO = 4'd8;
	localparam logic [3:0] PH_F1_HI  = 4'd9;
	localparam logic [3:0] PH_F1_LO  = 4'd10;
	localparam logic [3:0] PH_F2_HI  = 4'd11;
	localparam logic [3:0] PH_F2_LO  = 4'd12;
	localparam logic [3:0] PH_BODY   = 4'd13;
	localparam logic [3:0] PH_ERR    = 4'd14;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  held_q, held_d;
	logic [1:0]  kind_q, kind_d;
	logic [15:0] flag_q, flag_d;
	logic        unrep_q, unrep_d;
	logic        err_q, err_d;

	logic        accept;
	logic [15:0] word;
	logic [15:0] left_dec;
	logic        has_text;
	logic        is_ent;

	assign accept   = in_valid && in_ready;
	assign in_ready = !q_full;
	assign word     = {held_q, in_data.data_byte};
	assign left_dec = left_q - 16'd1;

	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		held_d   = held_q;
		kind_d   = kind_q;
		flag_d   = flag_q;
		unrep_d  = unrep_q;
		err_d    = err_q;
		has_text = 1'b0;
		is_ent   = 1'b0;
		unique case (phase_q)
			PH_H0: begin
				if (in_data.data_byte != HDR_B0) begin
					err_d   = 1'b1;
					phase_d = PH_ERR;
				end else begin
					phase_d = PH_H1;
				end
			end
			PH_H1: begin
				if (in_data.data_byte != MARK_B) begin
					err_d   = 1'b1;
					phase_d = PH_ERR;
				end else begin
					phase_d = PH_FL_HI;
				end
			end
			PH_FL_HI: begin
				held_d  = in_data.data_byte;
				phase_d = PH_FL_LO;
			end
			PH_FL_LO: begin
				left_d  = word;
				phase_d = (word != 16'd0) ? PH_FEAT : PH_S0;
			end
			PH_FEAT: begin
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_S0;
				end
			end
			PH_S0: begin
				if (in_data.data_byte != MARK_B) begin
					err_d   = 1'b1;
					phase_d = PH_ERR;
				end else begin
					phase_d = PH_S1;
				end
			end
			PH_S1: begin
				if (in_data.data_byte != MARK_B) begin
					err_d   = 1'b1;
					phase_d = PH_ERR;
				end else begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				held_d  = in_data.data_byte;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (word < SECT_MIN) begin
					phase_d = PH_S0;
				end else begin
					left_d  = word - SECT_MIN;
					phase_d = PH_F1_HI;
				end
			end
			PH_F1_HI: begin
				held_d  = in_data.data_byte;
				phase_d = PH_F1_LO;
			end
			PH_F1_LO: begin
				flag_d  = word;
				phase_d = PH_F2_HI;
			end
			PH_F2_HI: begin
				phase_d = PH_F2_LO;
			end
			PH_F2_LO: begin
				if (flag_q == FLAG_PLAIN || flag_q == FLAG_PLAIN3) begin
					kind_d = KIND_COPY;
				end else if (flag_q == FLAG_WIDE && !left_q[0]) begin
					kind_d = KIND_WIDE;
				end else begin
					kind_d  = KIND_SKIP;
					unrep_d = 1'b1;
				end
				phase_d = (left_q != 16'd0) ? PH_BODY : PH_S0;
			end
			PH_BODY: begin
				if (kind_q == KIND_COPY) begin
					has_text = 1'b1;
				end else if (kind_q == KIND_WIDE) begin
					if (!left_q[0]) begin
						held_d = in_data.data_byte;
					end else begin
						has_text = 1'b1;
						is_ent   = (word >= ASCII_LIMIT);
					end
				end
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_S0;
				end
			end
			PH_ERR: begin
			end
			default: begin
				err_d   = 1'b1;
				phase_d = PH_ERR;
			end
		endcase
	end

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.word   = 16'd0;
		cmd.done   = in_data.last_byte;
		cmd.status = ST_OK;
		if (has_text) begin
			if (is_ent) begin
				cmd.op   = OP_ENT;
				cmd.word = word;
			end else begin
				cmd.op   = OP_CHAR;
				cmd.word = (kind_q == KIND_COPY) ? {8'h00, in_data.data_byte}
					: {8'h00, word[7:0]};
			end
		end
		if (in_data.last_byte) begin
			if (err_d || phase_d != PH_S0) begin
				cmd.status = ST_ERR;
			end else if (unrep_d) begin
				cmd.status = ST_UNREP;
			end
		end
	end

	assign cmd_push = accept && (has_text || in_data.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_H0;
			left_q  <= '0;
			held_q  <= '0;
			kind_q  <= KIND_COPY;
			flag_q  <= '0;
			unrep_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				phase_q <= PH_H0;
				left_q  <= '0;
				held_q  <= '0;
				kind_q  <= KIND_COPY;
				flag_q  <= '0;
				unrep_q <= 1'b0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
				held_q  <= held_d;
				kind_q  <= kind_d;
				flag_q  <= flag_d;
				unrep_q <= unrep_d;
				err_q   <= err_d;
			end
		end
	end

	`IMTB_ASSERT_ALWAYS(a_err_phase, (err_q == (phase_q == PH_ERR)), "error flag and error phase disagree")
	`IMTB_ASSERT(a_unrep_skip, (kind_q == KIND_SKIP) |-> unrep_q, "skipped section without unrepresentable mark")

endmodule

// ===== sv/imtb_queue.sv =====
// Short command queue between the parser and the expander
`include "im_text_block_to_html_text_assert.svh"

module imtb_queue import imtb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`IMTB_ASSERT_ALWAYS(a_count_max, (count_q <= CW'(DEPTH)), "queue count beyond depth")
	`IMTB_ASSERT(a_count_up, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1), "queue count missed a push")

endmodule

// ===== sv/imtb_back.sv =====
// Back end: expands queued commands into text transfers through an output register
`include "im_text_block_to_html_text_assert.svh"

module imtb_back import imtb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head_cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       emit;
	logic       last_piece;
	logic [7:0] piece;

	assign emit       = head_valid && (!out_valid_q || out_ready);
	assign last_piece = (head_cmd.op != OP_ENT) || (idx_q == ENT_LAST);
	assign pop        = emit && last_piece;

	always_comb begin
		piece = 8'h00;
		if (head_cmd.op == OP_CHAR) begin
			piece = head_cmd.word[7:0];
		end else if (head_cmd.op == OP_ENT) begin
			unique case (idx_q)
				3'd0: piece = 8'h26;
				3'd1: piece = 8'h23;
				3'd2: piece = hex_char(head_cmd.word[15:12]);
				3'd3: piece = hex_char(head_cmd.word[11:8]);
				3'd4: piece = hex_char(head_cmd.word[7:4]);
				3'd5: piece = hex_char(head_cmd.word[3:0]);
				default: piece = 8'h3b;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.text_byte    <= piece;
			out_q.text_valid   <= (head_cmd.op != OP_NONE);
			out_q.run_end      <= last_piece;
			out_q.message_done <= last_piece && head_cmd.done;
			out_q.status       <= (last_piece && head_cmd.done) ? head_cmd.status : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			if (emit) begin
				idx_q <= last_piece ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`IMTB_ASSERT(a_done_end, (out_valid_q && out_q.message_done) |-> out_q.run_end, "message end not at end of run")
	`IMTB_ASSERT(a_idx_ent, (idx_q != 3'd0) |-> (head_valid && head_cmd.op == OP_ENT), "entity index without entity command")

endmodule

// ===== sv/im_text_block_to_html_text.sv =====
// Path: an accepted text byte's command is registered in the queue, then each of its results in the output register.
// Throughput: one input byte per cycle while the queue has room; one result per cycle out while out_ready is high.
// A 16-bit character of 128 or more expands to seven results, so wide text is limited by the output rate.
// The output register allows one result per cycle while out_ready is high; the queue absorbs bursts of input.
// Reset: arst_n asynchronous active low clears the parser, the queue pointers and count, and the output valid flag.
module im_text_block_to_html_text import imtb_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic q_full;
	logic cmd_push;
	cmd_t cmd;
	logic q_pop;
	logic head_valid;
	cmd_t head_cmd;

	imtb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	imtb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	imtb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
